// ===== design/mwo_pkg.sv =====
// ----------------------------------------------------------------------------
// mwo_pkg
// Shared types and constants of the multi-waveform oscillator.
// ----------------------------------------------------------------------------
package mwo_pkg;

	localparam int CFG_INDEX_BITS = 1;
	localparam int QUEUE_DEPTH    = 2;
	localparam int Q30_FRAC_BITS  = 30;
	localparam logic [63:0] Q30_ONE     = 64'd1 << Q30_FRAC_BITS;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	typedef enum logic [2:0] {
		WAVE_SINE     = 3'd0,
		WAVE_SQUARE   = 3'd1,
		WAVE_TRIANGLE = 3'd2,
		WAVE_SAWTOOTH = 3'd3,
		WAVE_PULSE    = 3'd4
	} wave_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_PHASE_STEP  = 1'b0,
		REG_PULSE_WIDTH = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		SRC_TABLE  = 1'b0,
		SRC_DIRECT = 1'b1
	} sample_src_t;

	typedef struct packed {
		sample_src_t src;
		logic        negate;
	} sample_ctl_t;

endpackage

// ===== design/mwo_front.sv =====
// ----------------------------------------------------------------------------
// mwo_front
// Phase accumulator, configuration registers and waveform classification.
// ----------------------------------------------------------------------------
module mwo_front
	import mwo_pkg::*;
#(
	parameter int PHASE_BITS       = 32,
	parameter int SAMPLE_BITS      = 16,
	parameter int SINE_TABLE_DEPTH = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
	input  logic [PHASE_BITS-1:0]         cfg_data,
	input  logic                          accept,
	input  logic [2:0]                    wave_select,
	output sample_ctl_t                   entry_ctl,
	output logic [$clog2(SINE_TABLE_DEPTH+1)-1:0] entry_addr,
	output logic [SAMPLE_BITS-1:0]        entry_direct
);

	localparam int ADDR_BITS = $clog2(SINE_TABLE_DEPTH + 1);
	localparam int PROD_BITS = PHASE_BITS + ADDR_BITS - 2;
	localparam logic [PHASE_BITS-2:0] STEP_RESET =
		(PHASE_BITS-1)'((64'd440 << PHASE_BITS) / 64'd44100);
	localparam logic [PHASE_BITS-1:0] PW_RESET = PHASE_BITS'(64'd1 << (PHASE_BITS - 1));
	localparam logic [PHASE_BITS-1:0] PW_LO =
		PHASE_BITS'(((64'd1 << PHASE_BITS) + 64'd50) / 64'd100);
	localparam logic [PHASE_BITS-1:0] PW_HI =
		PHASE_BITS'(((64'd1 << PHASE_BITS) * 64'd99 + 64'd50) / 64'd100);
	localparam logic [SAMPLE_BITS-1:0] POS_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic [SAMPLE_BITS-1:0] NEG_MAX = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	logic [PHASE_BITS-1:0]  phase_q;
	logic [PHASE_BITS-2:0]  step_q;
	logic [PHASE_BITS-1:0]  pulse_width_q;
	logic [PHASE_BITS-1:0]  pw_clamped;
	logic [PROD_BITS-1:0]   k_prod;
	logic [ADDR_BITS-1:0]   k;
	logic [PHASE_BITS+SAMPLE_BITS:0]   tri_wide;
	logic [PHASE_BITS+SAMPLE_BITS-1:0] saw_wide;
	logic [SAMPLE_BITS:0]   tri_top;
	logic [SAMPLE_BITS:0]   tri_abs;
	logic [SAMPLE_BITS-1:0] tri_val;
	logic [SAMPLE_BITS-1:0] saw_top;

	always_comb begin
		pw_clamped = cfg_data;
		if (cfg_data < PW_LO) begin
			pw_clamped = PW_LO;
		end else if (cfg_data > PW_HI) begin
			pw_clamped = PW_HI;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= '0;
			step_q        <= STEP_RESET;
			pulse_width_q <= PW_RESET;
		end else begin
			if (accept) begin
				phase_q <= phase_q + {1'b0, step_q};
			end
			if (cfg_write) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_PHASE_STEP:  step_q        <= cfg_data[PHASE_BITS-2:0];
					REG_PULSE_WIDTH: pulse_width_q <= pw_clamped;
				endcase
			end
		end
	end

	always_comb begin
		k_prod = PROD_BITS'(phase_q[PHASE_BITS-3:0]) * PROD_BITS'(SINE_TABLE_DEPTH);
		k      = k_prod[PROD_BITS-1:PHASE_BITS-2];

		tri_wide = {phase_q, {(SAMPLE_BITS+1){1'b0}}};
		tri_top  = tri_wide[PHASE_BITS+SAMPLE_BITS:PHASE_BITS];
		if (tri_top[SAMPLE_BITS]) begin
			tri_abs = {1'b0, tri_top[SAMPLE_BITS-1:0]};
		end else begin
			tri_abs = {1'b1, {SAMPLE_BITS{1'b0}}} - tri_top;
		end
		if (tri_abs[SAMPLE_BITS]) begin
			tri_val = POS_MAX;
		end else begin
			tri_val = {~tri_abs[SAMPLE_BITS-1], tri_abs[SAMPLE_BITS-2:0]};
		end

		saw_wide = {phase_q, {SAMPLE_BITS{1'b0}}};
		saw_top  = saw_wide[PHASE_BITS+SAMPLE_BITS-1:PHASE_BITS];

		entry_ctl.src    = SRC_DIRECT;
		entry_ctl.negate = phase_q[PHASE_BITS-1];
		entry_addr       = phase_q[PHASE_BITS-2] ? ADDR_BITS'(SINE_TABLE_DEPTH) - k : k;
		entry_direct     = '0;
		unique case (wave_t'(wave_select))
			WAVE_SINE:     entry_ctl.src = SRC_TABLE;
			WAVE_SQUARE:   entry_direct = phase_q[PHASE_BITS-1] ? NEG_MAX : POS_MAX;
			WAVE_TRIANGLE: entry_direct = tri_val;
			WAVE_SAWTOOTH: entry_direct = {~saw_top[SAMPLE_BITS-1], saw_top[SAMPLE_BITS-2:0]};
			WAVE_PULSE:    entry_direct = (phase_q < pulse_width_q) ? POS_MAX : NEG_MAX;
			default:       entry_direct = '0;
		endcase
	end

endmodule

// ===== design/mwo_queue.sv =====
// ----------------------------------------------------------------------------
// mwo_queue
// Two-entry queue between the classifying front and the sample back end.
// ----------------------------------------------------------------------------
module mwo_queue
	import mwo_pkg::*;
#(
	parameter int DATA_BITS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic [DATA_BITS-1:0] push_data,
	output logic                 full,
	input  logic                 pop,
	output logic                 head_valid,
	output logic [DATA_BITS-1:0] head_data
);

	localparam int PTR_BITS   = $clog2(QUEUE_DEPTH);
	localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

	logic [DATA_BITS-1:0]  mem_q [QUEUE_DEPTH];
	logic [PTR_BITS-1:0]   wr_ptr_q;
	logic [PTR_BITS-1:0]   rd_ptr_q;
	logic [COUNT_BITS-1:0] count_q;

	assign full       = (count_q == COUNT_BITS'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== design/mwo_back.sv =====
// ----------------------------------------------------------------------------
// mwo_back
// Quarter-wave sine ROM lookup, sign fold and the registered sample output.
// ----------------------------------------------------------------------------
module mwo_back
	import mwo_pkg::*;
#(
	parameter int SAMPLE_BITS      = 16,
	parameter int SINE_TABLE_DEPTH = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          head_valid,
	input  sample_ctl_t                   head_ctl,
	input  logic [$clog2(SINE_TABLE_DEPTH+1)-1:0] head_addr,
	input  logic [SAMPLE_BITS-1:0]        head_direct,
	output logic                          pop,
	output logic                          sample_valid,
	input  logic                          sample_stall,
	output logic signed [SAMPLE_BITS-1:0] sample_out
);

	localparam logic [63:0] HALF_SCALE = 64'd1 << (SAMPLE_BITS - 1);
	localparam logic [SAMPLE_BITS-1:0] POS_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

	typedef logic [SAMPLE_BITS-1:0] rom_t [0:SINE_TABLE_DEPTH];

	function automatic rom_t build_rom();
		rom_t        r;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		logic [63:0] e;
		for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
			x  = (HALF_PI_Q30 * 64'(i)) / SINE_TABLE_DEPTH;
			x2 = (x * x) >> Q30_FRAC_BITS;
			t  = Q30_ONE - x2 / 64'd110;
			t  = Q30_ONE - ((x2 * t) >> Q30_FRAC_BITS) / 64'd72;
			t  = Q30_ONE - ((x2 * t) >> Q30_FRAC_BITS) / 64'd42;
			t  = Q30_ONE - ((x2 * t) >> Q30_FRAC_BITS) / 64'd20;
			t  = Q30_ONE - ((x2 * t) >> Q30_FRAC_BITS) / 64'd6;
			s  = (x * t) >> Q30_FRAC_BITS;
			e  = (s * HALF_SCALE + (Q30_ONE >> 1)) >> Q30_FRAC_BITS;
			if (e > HALF_SCALE) begin
				e = HALF_SCALE;
			end
			r[i] = SAMPLE_BITS'(e);
		end
		return r;
	endfunction

	localparam rom_t SINE_ROM = build_rom();

	logic                   valid_s1;
	sample_ctl_t            ctl_s1;
	logic [SAMPLE_BITS-1:0] direct_s1;
	logic [SAMPLE_BITS-1:0] rom_s1;
	logic                   valid_s2;
	logic [SAMPLE_BITS-1:0] sample_s2;
	logic                   s1_ready;
	logic                   s2_ready;
	logic [SAMPLE_BITS-1:0] table_val;
	logic [SAMPLE_BITS-1:0] next_sample;

	assign s2_ready = !valid_s2 || !sample_stall;
	assign s1_ready = !valid_s1 || s2_ready;
	assign pop      = head_valid && s1_ready;

	always_comb begin
		if (ctl_s1.negate) begin
			table_val = ~rom_s1 + 1'b1;
		end else if (rom_s1[SAMPLE_BITS-1]) begin
			table_val = POS_MAX;
		end else begin
			table_val = rom_s1;
		end
		next_sample = (ctl_s1.src == SRC_TABLE) ? table_val : direct_s1;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ctl_s1    <= head_ctl;
			direct_s1 <= head_direct;
			rom_s1    <= SINE_ROM[head_addr];
		end
		if (s2_ready && valid_s1) begin
			sample_s2 <= next_sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s1_ready) begin
				valid_s1 <= head_valid;
			end
			if (s2_ready) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	assign sample_valid = valid_s2;
	assign sample_out   = signed'(sample_s2);

endmodule

// ===== design/multi_waveform_oscillator.sv =====
// ----------------------------------------------------------------------------
// multi_waveform_oscillator
// Takes one item per cycle while wave_stall is low; each accepted item passes
// through the queue, ROM and output register stages before its sample is
// offered, and the sample is held there while the output is stalled. Throughput
// is one sample per cycle when the output is not stalled.
// Reset clears the phase and loads the default step and a 50% pulse duty.
// Phase-accumulator oscillator with sine, square, triangle, sawtooth and
// pulse outputs in signed fixed point.
// ----------------------------------------------------------------------------
module multi_waveform_oscillator
	import mwo_pkg::*;
#(
	parameter int PHASE_BITS       = 32,
	parameter int SAMPLE_BITS      = 16,
	parameter int SINE_TABLE_DEPTH = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
	input  logic [PHASE_BITS-1:0]         cfg_data,
	input  logic                          wave_valid,
	output logic                          wave_stall,
	input  logic [2:0]                    wave_select,
	output logic                          sample_valid,
	input  logic                          sample_stall,
	output logic signed [SAMPLE_BITS-1:0] sample_out
);

	localparam int ADDR_BITS  = $clog2(SINE_TABLE_DEPTH + 1);
	localparam int ENTRY_BITS = $bits(sample_ctl_t) + ADDR_BITS + SAMPLE_BITS;

	logic                   accept;
	sample_ctl_t            f_ctl;
	logic [ADDR_BITS-1:0]   f_addr;
	logic [SAMPLE_BITS-1:0] f_direct;
	logic [ENTRY_BITS-1:0]  q_data;
	logic                   q_valid;
	logic                   q_pop;
	logic                   q_full;
	sample_ctl_t            h_ctl;
	logic [ADDR_BITS-1:0]   h_addr;
	logic [SAMPLE_BITS-1:0] h_direct;

	assign wave_stall = q_full;
	assign accept     = wave_valid && !q_full;
	assign {h_ctl, h_addr, h_direct} = q_data;

	mwo_front #(
		.PHASE_BITS       (PHASE_BITS),
		.SAMPLE_BITS      (SAMPLE_BITS),
		.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.accept       (accept),
		.wave_select  (wave_select),
		.entry_ctl    (f_ctl),
		.entry_addr   (f_addr),
		.entry_direct (f_direct)
	);

	mwo_queue #(
		.DATA_BITS (ENTRY_BITS)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (accept),
		.push_data  ({f_ctl, f_addr, f_direct}),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head_data  (q_data)
	);

	mwo_back #(
		.SAMPLE_BITS      (SAMPLE_BITS),
		.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (q_valid),
		.head_ctl     (h_ctl),
		.head_addr    (h_addr),
		.head_direct  (h_direct),
		.pop          (q_pop),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample_out   (sample_out)
	);

	a_accept_reaches_back: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> q_valid)
		else $error("accepted item not visible to back end");

	a_stall_after_push: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(wave_stall) |-> $past(accept))
		else $error("queue filled without an accepted item");

	a_no_stall_from_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !q_valid) |=> !wave_stall)
		else $error("queue full after a single push into an empty queue");

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the multi-waveform oscillator. A tracker object
// keeps its own phase, step and duty and predicts every sample from the
// selected waveform. Items are offered with random gaps, and the output side
// stalls at random and once holds off for a long stretch. Each received
// sample is compared in order against the tracker's prediction.
// ----------------------------------------------------------------------------
module tb_top;
	import mwo_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int          TABLE_DEPTH = 1024;
	localparam int          HALF_SCALE  = 32768;
	localparam int          POS_FULL    = HALF_SCALE - 1;
	localparam int          NEG_FULL    = -HALF_SCALE;
	localparam logic [31:0] RESET_STEP  = 32'd42852281;
	localparam logic [31:0] DUTY_LO     = 32'd42949673;
	localparam logic [31:0] DUTY_HI     = 32'd4252017623;
	localparam int          QUIET_LIMIT = 3000;
	localparam int          HOLD_CYCLES = 300;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_write = 1'b0;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [31:0]               cfg_data = '0;
	logic                      wave_valid = 1'b0;
	logic                      wave_stall;
	logic [2:0]                wave_select = '0;
	logic                      sample_valid;
	logic                      sample_stall = 1'b0;
	logic signed [15:0]        sample_out;

	int stall_pct = 30;
	bit hold_off_request = 1'b0;

	class dds_tracker;
		int                 quarter_wave [0:TABLE_DEPTH];
		logic [31:0]        phase;
		logic [31:0]        step;
		logic [31:0]        duty;
		logic signed [15:0] pending_samples [$];
		int                 mismatches;

		function new();
			longint unsigned one, x, x2, t, s, e;
			one = 64'd1 << 30;
			for (int i = 0; i <= TABLE_DEPTH; i++) begin
				x  = (64'd1686629713 * longint'(i)) / TABLE_DEPTH;
				x2 = (x * x) >> 30;
				t  = one - x2 / 110;
				t  = one - ((x2 * t) >> 30) / 72;
				t  = one - ((x2 * t) >> 30) / 42;
				t  = one - ((x2 * t) >> 30) / 20;
				t  = one - ((x2 * t) >> 30) / 6;
				s  = (x * t) >> 30;
				e  = (s * HALF_SCALE + (one >> 1)) >> 30;
				if (e > HALF_SCALE)
					e = HALF_SCALE;
				quarter_wave[i] = int'(e);
			end
			phase      = '0;
			step       = RESET_STEP;
			duty       = 32'h8000_0000;
			mismatches = 0;
		endfunction

		function void set_reg(cfg_reg_t idx, logic [31:0] data);
			case (idx)
				REG_PHASE_STEP: begin
					step = {1'b0, data[30:0]};
				end
				REG_PULSE_WIDTH: begin
					duty = data;
					if (duty < DUTY_LO)
						duty = DUTY_LO;
					if (duty > DUTY_HI)
						duty = DUTY_HI;
				end
				default: ;
			endcase
		endfunction

		function logic signed [15:0] sample_at(logic [2:0] sel, logic [31:0] p);
			int v;
			int w;
			case (wave_t'(sel))
				WAVE_SINE: begin
					v = p[30] ? quarter_wave[TABLE_DEPTH - int'(p[29:20])]
					          : quarter_wave[p[29:20]];
					if (p[31])
						v = -v;
				end
				WAVE_SQUARE: v = p[31] ? NEG_FULL : POS_FULL;
				WAVE_TRIANGLE: begin
					w = int'(p >> 15) - 2 * HALF_SCALE;
					if (w < 0)
						w = -w;
					v = w - HALF_SCALE;
				end
				WAVE_SAWTOOTH: v = int'(p >> 16) - HALF_SCALE;
				WAVE_PULSE: v = (p < duty) ? POS_FULL : NEG_FULL;
				default: v = 0;
			endcase
			if (v > POS_FULL)
				v = POS_FULL;
			return 16'(v);
		endfunction

		function void note_tick(logic [2:0] sel);
			pending_samples.push_back(sample_at(sel, phase));
			phase = phase + step;
		endfunction

		function void check_sample(logic signed [15:0] got);
			logic signed [15:0] want;
			if (pending_samples.size() == 0) begin
				$display("%0t: sample_out expected none, actual %0d", $time, got);
				mismatches++;
				return;
			end
			want = pending_samples.pop_front();
			if (got !== want) begin
				$display("%0t: sample_out expected %0d, actual %0d", $time, want, got);
				mismatches++;
			end
		endfunction
	endclass

	dds_tracker tracker = new();

	multi_waveform_oscillator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.wave_valid   (wave_valid),
		.wave_stall   (wave_stall),
		.wave_select  (wave_select),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample_out   (sample_out)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (sample_valid === 1'b1 && sample_stall === 1'b0)
			tracker.check_sample(sample_out);
	end

	initial begin : receiver
		forever begin
			@(posedge clk);
			if (hold_off_request) begin
				sample_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off_request = 1'b0;
				sample_stall <= 1'b0;
			end else begin
				sample_stall <= ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((wave_valid && !wave_stall) || (sample_valid && !sample_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("multi_waveform_oscillator verification failed");
		$finish;
	end

	function automatic logic [2:0] random_wave();
		if ($urandom_range(0, 9) == 0)
			return 3'($urandom_range(5, 7));
		return 3'($urandom_range(0, 4));
	endfunction

	task automatic offer_tick(logic [2:0] sel);
		wave_valid <= 1'b1;
		wave_select <= sel;
		do @(posedge clk); while (wave_stall !== 1'b0);
		tracker.note_tick(sel);
	endtask

	task automatic settle();
		wave_valid <= 1'b0;
		while (tracker.pending_samples.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [31:0] data);
		settle();
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_write <= 1'b0;
		tracker.set_reg(idx, data);
	endtask

	// Walks the phase to an exact value with the largest steps allowed.
	task automatic park_phase(logic [31:0] target);
		logic [31:0] gap;
		logic [31:0] hop;
		gap = target - tracker.phase;
		while (gap != 0) begin
			hop = (gap > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : gap;
			write_reg(REG_PHASE_STEP, hop);
			offer_tick(random_wave());
			gap = gap - hop;
		end
	endtask

	initial begin : stimulus
		logic [31:0] step_word;
		logic [31:0] duty_word;
		int          gap_pct;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int s = 0; s < 8; s++)
			offer_tick(3'(s));

		write_reg(REG_PULSE_WIDTH, 32'h0);
		park_phase(DUTY_LO - 1);
		write_reg(REG_PHASE_STEP, 32'd1);
		offer_tick(WAVE_PULSE);
		offer_tick(WAVE_PULSE);

		write_reg(REG_PULSE_WIDTH, 32'hFFFF_FFFF);
		park_phase(DUTY_HI - 1);
		write_reg(REG_PHASE_STEP, 32'd1);
		offer_tick(WAVE_PULSE);
		offer_tick(WAVE_PULSE);

		park_phase(32'h7FFF_FFFF);
		write_reg(REG_PHASE_STEP, 32'd1);
		offer_tick(WAVE_SQUARE);
		offer_tick(WAVE_SQUARE);

		park_phase(32'hFFFF_FFFF);
		write_reg(REG_PHASE_STEP, 32'd1);
		offer_tick(WAVE_TRIANGLE);
		offer_tick(WAVE_TRIANGLE);
		offer_tick(WAVE_SAWTOOTH);
		write_reg(REG_PHASE_STEP, 32'h4000_0000);
		repeat (4) offer_tick(WAVE_SINE);

		for (int round_no = 0; round_no < 17; round_no++) begin
			case (round_no)
				0: step_word = 32'h0;
				1: step_word = 32'hFFFF_FFFF;
				default: begin
					case ($urandom_range(0, 4))
						0: step_word = $urandom_range(1, 1 << 12);
						1: step_word = $urandom;
						2: step_word = 32'h7FFF_FFFF;
						default: step_word = $urandom_range(1 << 16, 1 << 27);
					endcase
				end
			endcase
			case (round_no)
				0: duty_word = 32'h0;
				1: duty_word = 32'hFFFF_FFFF;
				2: duty_word = DUTY_LO;
				3: duty_word = DUTY_HI;
				default: begin
					case ($urandom_range(0, 3))
						0: duty_word = $urandom_range(0, DUTY_LO);
						1: duty_word = $urandom_range(DUTY_HI, 32'hFFFF_FFFF);
						default: duty_word = $urandom;
					endcase
				end
			endcase
			write_reg(REG_PHASE_STEP, step_word);
			write_reg(REG_PULSE_WIDTH, duty_word);

			gap_pct = (round_no == 4) ? 0 : 30;
			stall_pct = (round_no == 4) ? 0 : 30;
			if (round_no == 8) begin
				gap_pct = 0;
				hold_off_request = 1'b1;
			end

			for (int n = 0; n < 100; n++) begin
				if (round_no == 11 && n == 50) begin
					settle();
				end else if ($urandom_range(0, 99) < gap_pct) begin
					wave_valid <= 1'b0;
					repeat ($urandom_range(1, 4)) @(posedge clk);
				end
				offer_tick(random_wave());
			end
		end

		settle();
		repeat (6) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.pending_samples.size() == 0)
			$display("multi_waveform_oscillator verification clean");
		else
			$display("multi_waveform_oscillator verification failed");
		$finish;
	end

endmodule
